### rtl/wrs_pkg.sv
// Shared types, codes and constants of the water refill supervisor.
`timescale 1ns / 1ps
package wrs_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int LEVEL_W       = 10;
  localparam int COUNT_W       = 8;
  localparam int MS_W          = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 3;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_STARTED     = 4'd1,
    EV_REJECTED    = 4'd2,
    EV_COMPLETE    = 4'd3,
    EV_CONTINUOUS  = 4'd4,
    EV_NO_PROGRESS = 4'd5,
    EV_STALLED     = 4'd6,
    EV_MAX_RUNTIME = 4'd7,
    EV_SAFETY      = 4'd8
  } event_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HIGH_THRESHOLD = 3'd0,
    REG_PROGRESS_DELTA = 3'd1,
    REG_CONFIRMATIONS  = 3'd2,
    REG_CHECK_INTERVAL = 3'd3,
    REG_ATTEMPT        = 3'd4,
    REG_STALL_TIMEOUT  = 3'd5,
    REG_MAX_CONTINUOUS = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] high_threshold;
    logic [LEVEL_W-1:0] progress_delta;
    logic [COUNT_W-1:0] confirmations_needed;
    logic [MS_W-1:0]    check_interval_ms;
    logic [MS_W-1:0]    attempt_ms;
    logic [MS_W-1:0]    stall_timeout_ms;
    logic [MS_W-1:0]    max_continuous_ms;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [MS_W-1:0]    now_ms;
    logic [LEVEL_W-1:0] water_level;
    logic [LEVEL_W-1:0] baseline_level;
  } request_t;

  typedef struct packed {
    logic               low_water_alert;
    event_t             event_code;
    logic [1:0]         refill_mode;
    logic               solenoid_on;
  } result_t;

  localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 10'd900;
  localparam logic [LEVEL_W-1:0] PROGRESS_DELTA_RST = 10'd20;
  localparam logic [COUNT_W-1:0] CONFIRMATIONS_RST  = 8'd2;
  localparam logic [MS_W-1:0]    CHECK_INTERVAL_RST = 32'd1000;
  localparam logic [MS_W-1:0]    ATTEMPT_RST        = 32'd30000;
  localparam logic [MS_W-1:0]    STALL_TIMEOUT_RST  = 32'd60000;
  localparam logic [MS_W-1:0]    MAX_CONTINUOUS_RST = 32'd600000;

endpackage

### rtl/water_refill_supervisor.sv
// Top level of the water refill supervisor: request and result stages.
`timescale 1ns / 1ps
// Takes one request per clock cycle while the output is not held back and
// delivers one result for each: a request is captured in the input stage,
// the whole decision and the state update happen as it moves on to the
// output stage, and the result waits in the output stage until it is taken.
// The sustained rate of one request per cycle is set by the state update
// loop in the core. Configuration writes are registered.
module water_refill_supervisor
  import wrs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operation[1:0], now_ms[33:2], water_level[43:34], baseline_level[53:44]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // solenoid_on[0], refill_mode[2:1], event_code[6:3], low_water_alert[7]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  request_t req;
  result_t  core_res, out_res;
  logic     req_valid;
  logic     advance, fire;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = req_valid && advance;
  assign s_axis_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        req_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.op             <= op_t'(s_axis_tdata[1:0]);
      req.now_ms         <= s_axis_tdata[33:2];
      req.water_level    <= s_axis_tdata[43:34];
      req.baseline_level <= s_axis_tdata[53:44];
    end
    if (fire) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {out_res.low_water_alert, out_res.event_code,
                         out_res.refill_mode, out_res.solenoid_on};

  wrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wrs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .cfg  (cfg),
    .res  (core_res)
  );

endmodule

### rtl/wrs_cfg_regs.sv
// Configuration register file of the water refill supervisor.
`timescale 1ns / 1ps
module wrs_cfg_regs
  import wrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold       <= HIGH_THRESHOLD_RST;
      cfg.progress_delta       <= PROGRESS_DELTA_RST;
      cfg.confirmations_needed <= CONFIRMATIONS_RST;
      cfg.check_interval_ms    <= CHECK_INTERVAL_RST;
      cfg.attempt_ms           <= ATTEMPT_RST;
      cfg.stall_timeout_ms     <= STALL_TIMEOUT_RST;
      cfg.max_continuous_ms    <= MAX_CONTINUOUS_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_HIGH_THRESHOLD: cfg.high_threshold       <= cfg_data[LEVEL_W-1:0];
        REG_PROGRESS_DELTA: cfg.progress_delta       <= cfg_data[LEVEL_W-1:0];
        REG_CONFIRMATIONS:  cfg.confirmations_needed <= cfg_data[COUNT_W-1:0];
        REG_CHECK_INTERVAL: cfg.check_interval_ms    <= cfg_data[MS_W-1:0];
        REG_ATTEMPT:        cfg.attempt_ms           <= cfg_data[MS_W-1:0];
        REG_STALL_TIMEOUT:  cfg.stall_timeout_ms     <= cfg_data[MS_W-1:0];
        REG_MAX_CONTINUOUS: cfg.max_continuous_ms    <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/wrs_core.sv
// Refill state and the combinational decision logic for one request.
`timescale 1ns / 1ps
module wrs_core
  import wrs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  request_t req,
  input  cfg_t     cfg,
  output result_t  res
);

  // Time differences are compared at the wider of the time and setting widths.
  localparam int CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_PROBING    = 2'd1,
    MODE_CONTINUOUS = 2'd2
  } mode_t;

  mode_t                mode, mode_next;
  logic [TIME_BITS-1:0] start_time, start_time_next;
  logic [TIME_BITS-1:0] last_check_time, last_check_time_next;
  logic [TIME_BITS-1:0] last_progress_time, last_progress_time_next;
  logic [LEVEL_W-1:0]   baseline, baseline_next;
  logic [LEVEL_W-1:0]   last_progress_level, last_progress_level_next;
  logic [COUNT_W-1:0]   progress_count, progress_count_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] el_check, el_start, el_progress, progress_time_eff;
  logic                 too_early, attempt_over, stalled, runtime_over;
  logic                 rise, progress;
  logic [COUNT_W-1:0]   count_inc;
  event_t               ev;

  assign now_t    = TIME_BITS'(req.now_ms);
  assign el_check = now_t - last_check_time;
  assign el_start = now_t - start_time;

  // Level sums are one bit wider so that they cannot wrap.
  assign rise     = {1'b0, req.water_level} >=
                    ({1'b0, baseline} + {1'b0, cfg.progress_delta});
  assign progress = {1'b0, req.water_level} >=
                    ({1'b0, last_progress_level} + {1'b0, cfg.progress_delta});

  assign count_inc = !rise ? '0 :
                     (progress_count == COUNT_MAX) ? COUNT_MAX : progress_count + 1'b1;

  assign progress_time_eff = progress ? now_t : last_progress_time;
  assign el_progress       = now_t - progress_time_eff;

  assign too_early    = CMP_W'(el_check) < CMP_W'(cfg.check_interval_ms);
  assign attempt_over = CMP_W'(el_start) >= CMP_W'(cfg.attempt_ms);
  assign stalled      = CMP_W'(el_progress) >= CMP_W'(cfg.stall_timeout_ms);
  assign runtime_over = CMP_W'(el_start) >= CMP_W'(cfg.max_continuous_ms);

  always_comb begin
    mode_next                = mode;
    start_time_next          = start_time;
    last_check_time_next     = last_check_time;
    last_progress_time_next  = last_progress_time;
    baseline_next            = baseline;
    last_progress_level_next = last_progress_level;
    progress_count_next      = progress_count;
    ev                       = EV_NONE;
    case (req.op)
      OP_CHECK: begin
        if (mode != MODE_IDLE && !too_early) begin
          last_check_time_next = now_t;
          if (req.water_level >= cfg.high_threshold) begin
            mode_next           = MODE_IDLE;
            progress_count_next = '0;
            ev                  = EV_COMPLETE;
          end else if (mode == MODE_PROBING) begin
            progress_count_next = count_inc;
            if (count_inc >= cfg.confirmations_needed) begin
              mode_next                = MODE_CONTINUOUS;
              last_progress_level_next = req.water_level;
              last_progress_time_next  = now_t;
              ev                       = EV_CONTINUOUS;
            end else if (attempt_over) begin
              mode_next           = MODE_IDLE;
              progress_count_next = '0;
              ev                  = EV_NO_PROGRESS;
            end
          end else begin
            if (progress) begin
              last_progress_level_next = req.water_level;
              last_progress_time_next  = now_t;
            end
            if (stalled) begin
              mode_next           = MODE_IDLE;
              progress_count_next = '0;
              ev                  = EV_STALLED;
            end else if (runtime_over) begin
              mode_next           = MODE_IDLE;
              progress_count_next = '0;
              ev                  = EV_MAX_RUNTIME;
            end
          end
        end
      end
      OP_START: begin
        if (mode != MODE_IDLE) begin
          ev = EV_REJECTED;
        end else begin
          mode_next                = MODE_PROBING;
          start_time_next          = now_t;
          last_check_time_next     = now_t;
          last_progress_time_next  = now_t;
          baseline_next            = req.baseline_level;
          last_progress_level_next = req.baseline_level;
          progress_count_next      = '0;
          ev                       = EV_STARTED;
        end
      end
      OP_STOP: begin
        mode_next = MODE_IDLE;
        ev        = EV_SAFETY;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.solenoid_on     = (mode_next != MODE_IDLE);
    res.refill_mode     = 2'(mode_next);
    res.event_code      = ev;
    res.low_water_alert = ev inside {EV_NO_PROGRESS, EV_STALLED, EV_MAX_RUNTIME};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_IDLE;
      start_time          <= '0;
      last_check_time     <= '0;
      last_progress_time  <= '0;
      baseline            <= '0;
      last_progress_level <= '0;
      progress_count      <= '0;
    end else if (fire) begin
      mode                <= mode_next;
      start_time          <= start_time_next;
      last_check_time     <= last_check_time_next;
      last_progress_time  <= last_progress_time_next;
      baseline            <= baseline_next;
      last_progress_level <= last_progress_level_next;
      progress_count      <= progress_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Continuous mode is only reachable through probing.
  a_no_direct_continuous: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == MODE_IDLE) |=> (mode != MODE_CONTINUOUS))
    else $error("continuous mode entered directly from idle");

  // An accepted start while idle always opens a probing attempt.
  a_start_probes: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == MODE_IDLE && req.op == OP_START) |=>
      (mode == MODE_PROBING && progress_count == '0))
    else $error("start request did not open a probing attempt");

  // State only moves when a request is processed.
  a_hold_without_request: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(mode) && $stable(progress_count) && $stable(last_check_time)))
    else $error("supervisor state changed without a request");

  // A pause alert always leaves the supervisor idle with the solenoid closed.
  a_alert_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && res.low_water_alert) |->
      (!res.solenoid_on && res.refill_mode == 2'(MODE_IDLE)))
    else $error("pause alert raised while the supervisor keeps running");
`endif

endmodule
